FILE: design/emf_pkg.sv
// ----------------------------------------------------------------------------
// emf_pkg - shared types and helpers for the moveable feasts core
// Beat payloads, inter-stage records, calendar tables and date helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package emf_pkg;

    localparam int NUM_STAGES  = 9;
    localparam int FRONT_DEPTH = 3;
    localparam int COMP_DEPTH  = 4;
    localparam int DATE_DEPTH  = 2;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [2:0] MONTH_MAR = 3'd3;
    localparam logic [2:0] MONTH_APR = 3'd4;

    // last day of year of January .. June in a common year
    localparam logic [7:0] MONTH_END [6] = '{8'd31, 8'd59, 8'd90, 8'd120, 8'd151, 8'd181};

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  query_month;
    } req_t;

    typedef struct packed {
        logic [4:0] month_length;
        logic [4:0] easter_dom;
        logic [2:0] easter_mon;
        logic [4:0] carnival_dom;
        logic [1:0] carnival_mon;
        logic [4:0] good_friday_dom;
        logic [2:0] good_friday_mon;
        logic [4:0] ascension_dom;
        logic [2:0] ascension_mon;
        logic [4:0] whitsun_dom;
        logic [2:0] whitsun_mon;
    } rsp_t;

    typedef struct packed {
        logic [4:0] a;
        logic [7:0] b;
        logic [6:0] c;
        logic [5:0] g;
        logic       leap;
        logic [4:0] month_length;
    } front_t;

    typedef struct packed {
        logic [4:0] dom;
        logic [2:0] mon;
        logic       leap;
        logic [4:0] month_length;
    } comp_t;

    typedef struct packed {
        logic [4:0] dom;
        logic [2:0] mon;
    } date_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic date_t date_of(input logic [7:0] doy, input logic leap);
        date_t      dt;
        logic [7:0] start;
        logic [7:0] lim;
        start  = 8'd0;
        dt.mon = 3'd1;
        for (int j = 0; j < 6; j++)
        begin
            lim = MONTH_END[j] + ((j > 0) ? {7'd0, leap} : 8'd0);
            if (doy > lim)
            begin
                start  = lim;
                dt.mon = 3'(j + 2);
            end
        end
        dt.dom = 5'(doy - start);
        return dt;
    endfunction

endpackage

`default_nettype wire

FILE: design/easter_and_moveable_feasts_core.sv
// ----------------------------------------------------------------------------
// easter_and_moveable_feasts_core - Easter and moveable feasts of a year
// Gregorian computus, feast dates and month length in a nine-stage pipeline.
// ----------------------------------------------------------------------------
//   channel | signals                          | beat
//   req     | req_valid, req_ready, req_data   | year, query_month
//   rsp     | rsp_valid, rsp_ready, rsp_data   | month length and five dates
//
// One beat in per cycle while req_ready is high.
// Nine register stages, each holding a valid bit; reset clears only those.
// A stalled rsp holds its beat; earlier stages keep loading into empty
// slots, so bubbles close up and req_ready stays high while any stage is free.
// ----------------------------------------------------------------------------
`default_nettype none

module easter_and_moveable_feasts_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  emf_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output emf_pkg::rsp_t rsp_data
);
    import emf_pkg::*;

    logic [NUM_STAGES-1:0] stage_en;
    front_t                front;
    comp_t                 easter;

    emf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stage_en  (stage_en),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

    emf_front u_front (
        .clk      (clk),
        .en       (stage_en[FRONT_DEPTH-1:0]),
        .req_data (req_data),
        .front    (front)
    );

    emf_computus u_computus (
        .clk    (clk),
        .en     (stage_en[FRONT_DEPTH+COMP_DEPTH-1:FRONT_DEPTH]),
        .front  (front),
        .easter (easter)
    );

    emf_dates u_dates (
        .clk      (clk),
        .en       (stage_en[NUM_STAGES-1:FRONT_DEPTH+COMP_DEPTH]),
        .easter   (easter),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire

FILE: design/emf_ctrl.sv
// ----------------------------------------------------------------------------
// emf_ctrl - pipeline valid tracking and stage enables
// Valid bit per stage; a stage loads when it is empty or its beat moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module emf_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    output logic [emf_pkg::NUM_STAGES-1:0] stage_en,
    output logic                           rsp_valid,
    input  logic                           rsp_ready
);
    import emf_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   rdy;

    always_comb
    begin
        rdy[NUM_STAGES] = rsp_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        valid_next[0] = rdy[0] ? req_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign stage_en  = rdy[NUM_STAGES-1:0];
    assign req_ready = rdy[0];
    assign rsp_valid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

FILE: design/emf_front.sv
// ----------------------------------------------------------------------------
// emf_front - year split, leap flag, month length and century terms
// Three stages: reciprocal products, remainders, century correction g.
// ----------------------------------------------------------------------------
`default_nettype none

module emf_front (
    input  logic                            clk,
    input  logic [emf_pkg::FRONT_DEPTH-1:0] en,
    input  emf_pkg::req_t                   req_data,
    output emf_pkg::front_t                 front
);
    import emf_pkg::*;

    logic [13:0] y1_reg;
    logic [3:0]  qm1_reg;
    logic [7:0]  q100_reg;
    logic [9:0]  q19_reg;
    logic [26:0] p100;
    logic [29:0] p19;

    logic [4:0]  a2_reg;
    logic [7:0]  b2_reg;
    logic [6:0]  c2_reg;
    logic [2:0]  f2_reg;
    logic        leap2_reg;
    logic [4:0]  ml2_reg;
    logic [13:0] c_w;
    logic [13:0] a_w;
    logic [13:0] f_p;
    logic        leap_w;

    logic [7:0]  x_w;
    logic [14:0] g_p;
    front_t      front_reg;
    front_t      front_next;

    // quotients by 100 and 19 through reciprocal products
    assign p100 = 27'(req_data.year) * 27'd5243;
    assign p19  = 30'(req_data.year) * 30'd55189;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y1_reg   <= req_data.year;
            qm1_reg  <= req_data.query_month;
            q100_reg <= p100[26:19];
            q19_reg  <= p19[29:20];
        end
    end

    assign c_w    = y1_reg - 14'(q100_reg) * 14'd100;
    assign a_w    = y1_reg - 14'(q19_reg) * 14'd19;
    assign f_p    = 14'(8'(q100_reg + 8'd8)) * 14'd41;
    assign leap_w = (y1_reg[1:0] == 2'd0) && ((c_w[6:0] != 7'd0) || (q100_reg[1:0] == 2'd0));

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a2_reg    <= a_w[4:0];
            b2_reg    <= q100_reg;
            c2_reg    <= c_w[6:0];
            f2_reg    <= f_p[12:10];
            leap2_reg <= leap_w;
            ml2_reg   <= month_len(leap_w, qm1_reg);
        end
    end

    assign x_w = b2_reg - 8'(f2_reg) + 8'd1;
    assign g_p = 15'(x_w) * 15'd171;

    always_comb
    begin
        front_next.a            = a2_reg;
        front_next.b            = b2_reg;
        front_next.c            = c2_reg;
        front_next.g            = g_p[14:9];
        front_next.leap         = leap2_reg;
        front_next.month_length = ml2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

FILE: design/emf_computus.sv
// ----------------------------------------------------------------------------
// emf_computus - epact, weekday offset and Easter Sunday
// Four stages: h product, h and l sum, l product, correction and date.
// ----------------------------------------------------------------------------
`default_nettype none

module emf_computus (
    input  logic                           clk,
    input  logic [emf_pkg::COMP_DEPTH-1:0] en,
    input  emf_pkg::front_t                front,
    output emf_pkg::comp_t                 easter
);
    import emf_pkg::*;

    logic [9:0]  hp_w;
    logic [20:0] hq_p;
    logic [9:0]  hp4_reg;
    logic [4:0]  hq4_reg;
    logic [1:0]  e4_reg;
    logic [4:0]  i4_reg;
    logic [1:0]  k4_reg;
    logic [4:0]  a4_reg;
    logic        leap4_reg;
    logic [4:0]  ml4_reg;

    logic [9:0]  h_w;
    logic [6:0]  lp_w;
    logic [4:0]  h5_reg;
    logic [6:0]  lp5_reg;
    logic [4:0]  a5_reg;
    logic        leap5_reg;
    logic [4:0]  ml5_reg;

    logic [15:0] lq_p;
    logic [4:0]  h6_reg;
    logic [6:0]  lp6_reg;
    logic [3:0]  lq6_reg;
    logic [4:0]  a6_reg;
    logic        leap6_reg;
    logic [4:0]  ml6_reg;

    logic [6:0]  l_w;
    logic [8:0]  s_w;
    logic [7:0]  base_w;
    logic        apr_w;
    logic [7:0]  dom_w;
    comp_t       easter_reg;
    comp_t       easter_next;

    assign hp_w = 10'(front.a) * 10'd19 + 10'(front.b) - 10'(front.b[7:2])
                - 10'(front.g) + 10'd15;
    assign hq_p = 21'(hp_w) * 21'd1093;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hp4_reg   <= hp_w;
            hq4_reg   <= hq_p[19:15];
            e4_reg    <= front.b[1:0];
            i4_reg    <= front.c[6:2];
            k4_reg    <= front.c[1:0];
            a4_reg    <= front.a;
            leap4_reg <= front.leap;
            ml4_reg   <= front.month_length;
        end
    end

    assign h_w  = hp4_reg - 10'(hq4_reg) * 10'd30;
    assign lp_w = 7'd32 + {4'd0, e4_reg, 1'b0} + {1'b0, i4_reg, 1'b0}
                - 7'(h_w[4:0]) - 7'(k4_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            h5_reg    <= h_w[4:0];
            lp5_reg   <= lp_w;
            a5_reg    <= a4_reg;
            leap5_reg <= leap4_reg;
            ml5_reg   <= ml4_reg;
        end
    end

    assign lq_p = 16'(lp5_reg) * 16'd293;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            h6_reg    <= h5_reg;
            lp6_reg   <= lp5_reg;
            lq6_reg   <= lq_p[14:11];
            a6_reg    <= a5_reg;
            leap6_reg <= leap5_reg;
            ml6_reg   <= ml5_reg;
        end
    end

    assign l_w    = lp6_reg - 7'(lq6_reg) * 7'd7;
    assign s_w    = 9'(a6_reg) + 9'(h6_reg) * 9'd11 + 9'(l_w[2:0]) * 9'd22;
    assign base_w = 8'(h6_reg) + 8'(l_w[2:0]) + 8'd114 - ((s_w >= 9'd451) ? 8'd7 : 8'd0);
    assign apr_w  = base_w >= 8'd124;
    assign dom_w  = base_w - (apr_w ? 8'd123 : 8'd92);

    always_comb
    begin
        easter_next.dom          = dom_w[4:0];
        easter_next.mon          = apr_w ? MONTH_APR : MONTH_MAR;
        easter_next.leap         = leap6_reg;
        easter_next.month_length = ml6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            easter_reg <= easter_next;
        end
    end

    assign easter = easter_reg;

endmodule

`default_nettype wire

FILE: design/emf_dates.sv
// ----------------------------------------------------------------------------
// emf_dates - feast day numbers and calendar dates
// Two stages: day of year of each feast, then day and month of each.
// ----------------------------------------------------------------------------
`default_nettype none

module emf_dates (
    input  logic                           clk,
    input  logic [emf_pkg::DATE_DEPTH-1:0] en,
    input  emf_pkg::comp_t                 easter,
    output emf_pkg::rsp_t                  rsp_data
);
    import emf_pkg::*;

    logic [6:0] doy_w;
    logic [7:0] carn8_reg;
    logic [7:0] gf8_reg;
    logic [7:0] asc8_reg;
    logic [7:0] whit8_reg;
    comp_t      easter8_reg;

    date_t      carn_d;
    date_t      gf_d;
    date_t      asc_d;
    date_t      whit_d;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;

    assign doy_w = 7'(easter.dom) + ((easter.mon == MONTH_APR) ? 7'd90 : 7'd59)
                 + 7'(easter.leap);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            carn8_reg   <= 8'(doy_w) - 8'd49;
            gf8_reg     <= 8'(doy_w) - 8'd2;
            asc8_reg    <= 8'(doy_w) + 8'd39;
            whit8_reg   <= 8'(doy_w) + 8'd49;
            easter8_reg <= easter;
        end
    end

    assign carn_d = date_of(carn8_reg, easter8_reg.leap);
    assign gf_d   = date_of(gf8_reg, easter8_reg.leap);
    assign asc_d  = date_of(asc8_reg, easter8_reg.leap);
    assign whit_d = date_of(whit8_reg, easter8_reg.leap);

    always_comb
    begin
        rsp_next.month_length    = easter8_reg.month_length;
        rsp_next.easter_dom      = easter8_reg.dom;
        rsp_next.easter_mon      = easter8_reg.mon;
        rsp_next.carnival_dom    = carn_d.dom;
        rsp_next.carnival_mon    = carn_d.mon[1:0];
        rsp_next.good_friday_dom = gf_d.dom;
        rsp_next.good_friday_mon = gf_d.mon;
        rsp_next.ascension_dom   = asc_d.dom;
        rsp_next.ascension_mon   = asc_d.mon;
        rsp_next.whitsun_dom     = whit_d.dom;
        rsp_next.whitsun_mon     = whit_d.mon;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

FILE: design/emf_checker.sv
// ----------------------------------------------------------------------------
// emf_checker - port-level checks for the moveable feasts core
// Watches the rsp channel and the readiness chain; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module emf_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input emf_pkg::rsp_t rsp_data
);
    import emf_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("rsp beat changed while stalled");

    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("req held off while rsp side drains");

    a_easter_window: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.easter_mon == MONTH_MAR && rsp_data.easter_dom >= 5'd22)
                   || (rsp_data.easter_mon == MONTH_APR && rsp_data.easter_dom <= 5'd25))
        else $error("Easter outside 22 March to 25 April");

    a_good_friday: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.easter_dom >= 5'd3
        |-> rsp_data.good_friday_mon == rsp_data.easter_mon
         && rsp_data.good_friday_dom == rsp_data.easter_dom - 5'd2)
        else $error("Good Friday not two days before Easter");

endmodule

bind easter_and_moveable_feasts_core emf_checker u_emf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire
